// ===== hdl/pss_pkg.sv =====
// pss_pkg: shared types and constants of the prime sum sieve.
// No dependencies.
`timescale 1ns / 1ps

package pss_pkg;

   localparam int PRIME_SUM_BITS = 47;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/pss_div.sv =====
// pss_div: restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_div #(
   parameter int WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [WIDTH-1:0]       numerator,
   input  logic [WIDTH-1:0]       denominator,
   output pss_pkg::div_status_type status,
   output logic [WIDTH-1:0]       quotient
);
   import pss_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [WIDTH:0]   rem_sh;
   logic             fits;

   assign rem_sh = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            rem_ff  <= '0;
            quo_ff  <= numerator;
            den_ff  <= denominator;
            cnt_ff  <= CNT_W'(WIDTH);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            quo_ff <= {quo_ff[WIDTH-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      go |-> !busy_ff) else $error("divider restarted while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a running division");

endmodule

// ===== hdl/prime_sum_sieve_unit.sv =====
// prime_sum_sieve_unit: one item at a time; an endpoint below two goes straight to output.
// Otherwise the fill divides for each of the C quotient values (C about 2*sqrt(n)),
// then each sieve update divides v by p, and again when v/p lies above the root.
// The shared bit-serial divider sets the pace.
// Synchronous reset clears control only; the tables are rebuilt by every item of endpoint two or more.
// Depends on pss_pkg and pss_div.
`timescale 1ns / 1ps

module prime_sum_sieve_unit #(
   parameter int ENDPOINT_BITS = 24,
   parameter int TABLE_DEPTH   = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ENDPOINT_BITS-1:0]           req_endpoint,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pss_pkg::PRIME_SUM_BITS-1:0] rsp_prime_sum
);
   import pss_pkg::*;

   localparam int N           = ENDPOINT_BITS;
   localparam int SW          = 2 * N;
   localparam int HB          = (N + 1) / 2;
   localparam int RW          = HB + 1;
   localparam int CW          = HB + 2;
   localparam int LW          = HB + 1;
   localparam int LARGE_DEPTH = (1 << HB) + 1;
   localparam int IW          = $clog2(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE, S_SQ_CHK, S_SQ_DIV, S_CNT_DIV, S_F_V, S_F_H, S_F_W,
      S_P_RD0, S_P_RD1, S_P_CMP, S_P_NX,
      S_I_CHK, S_I_VAL, S_I_Q, S_I_POS, S_I_LA, S_I_LS, S_I_RS, S_I_RR,
      S_I_M0, S_I_M1, S_I_WR, S_FIN_RD, S_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic [N-1:0]  n_ff, x_ff, v_ff, high_ff, pos_ff;
   logic [N:0]    y_ff;
   logic [RW-1:0] r_ff, p_ff;
   logic [CW-1:0] count_ff, idx_ff, i_ff, slot_ff;
   logic [2*RW-1:0] sq_ff;
   logic [2*N:0]  tri_ff;
   logic [SW-1:0] before_ff, diff_ff, cur_ff, lo_ff, hi_ff;
   logic [PRIME_SUM_BITS-1:0] res_ff, rsp_sum_ff;
   logic          rsp_valid_ff;

   logic          div_go_ff;
   logic [N-1:0]  div_num_ff, div_den_ff, div_q;
   div_status_type div_st;

   logic [N-1:0]  qv_mem [TABLE_DEPTH];
   logic [SW-1:0] ps_mem [TABLE_DEPTH];
   logic [CW-1:0] ls_mem [LARGE_DEPTH];
   logic [N-1:0]  qv_rd_ff;
   logic [SW-1:0] ps_rd_ff;
   logic [CW-1:0] ls_rd_ff;
   logic          ps_ok_ff;

   logic          qv_we, ps_we, ls_we, ps_rok;
   logic [IW-1:0] qv_ra, ps_ra, ps_wa;
   logic [SW-1:0] ps_wd, ps_val;
   logic [CW-1:0] rd_slot;
   logic [RW+N-1:0] mul_lo, mul_hi;

   pss_div #(.WIDTH(N)) u_div (
      .clock       (clock),
      .reset       (reset),
      .go          (div_go_ff),
      .numerator   (div_num_ff),
      .denominator (div_den_ff),
      .status      (div_st),
      .quotient    (div_q)
   );

   assign ps_val = ps_ok_ff ? ps_rd_ff : '0;
   assign mul_lo = (RW+N)'(p_ff) * (RW+N)'(diff_ff[N-1:0]);
   assign mul_hi = (RW+N)'(p_ff) * (RW+N)'(diff_ff[SW-1:N]);

   always_comb begin
      qv_we   = 1'b0;
      ps_we   = 1'b0;
      ls_we   = 1'b0;
      ps_wa   = IW'(idx_ff);
      ps_wd   = SW'(tri_ff >> 1) - SW'(1);
      qv_ra   = IW'(i_ff);
      rd_slot = '0;
      ps_rok  = 1'b1;
      if (v_ff < N'(2)) begin
         ps_wd = '0;
      end
      unique case (state_ff)
         S_F_W: begin
            qv_we = 32'(idx_ff) < TABLE_DEPTH;
            ps_we = 32'(idx_ff) < TABLE_DEPTH;
            ls_we = (v_ff > N'(r_ff)) && (32'(high_ff) < LARGE_DEPTH);
         end
         S_I_WR: begin
            ps_we = 1'b1;
            ps_wa = IW'(i_ff);
            ps_wd = cur_ff - lo_ff - hi_ff;
         end
         S_P_RD0: rd_slot = count_ff - CW'(p_ff - 1'b1);
         S_P_RD1: rd_slot = count_ff - CW'(p_ff);
         S_I_RS:  rd_slot = slot_ff;
         S_I_RR:  rd_slot = i_ff;
         default: rd_slot = '0;
      endcase
      ps_rok = 32'(rd_slot) < TABLE_DEPTH;
      ps_ra  = IW'(rd_slot);
   end

   always_ff @(posedge clock) begin
      if (qv_we) begin
         qv_mem[ps_wa] <= v_ff;
      end
      if (ps_we) begin
         ps_mem[ps_wa] <= ps_wd;
      end
      if (ls_we) begin
         ls_mem[LW'(high_ff)] <= idx_ff;
      end
      qv_rd_ff <= qv_mem[qv_ra];
      ps_rd_ff <= ps_mem[ps_ra];
      ls_rd_ff <= ls_mem[LW'(pos_ff)];
      ps_ok_ff <= ps_rok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_endpoint < N'(2)) begin
                     res_ff   <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     n_ff     <= req_endpoint;
                     x_ff     <= req_endpoint;
                     y_ff     <= ((N+1)'(req_endpoint) + 1'b1) >> 1;
                     state_ff <= S_SQ_CHK;
                  end
               end
            end
            S_SQ_CHK: begin
               div_go_ff  <= 1'b1;
               div_num_ff <= n_ff;
               if (y_ff < (N+1)'(x_ff)) begin
                  x_ff       <= N'(y_ff);
                  div_den_ff <= N'(y_ff);
                  state_ff   <= S_SQ_DIV;
               end else begin
                  r_ff       <= RW'(x_ff);
                  div_den_ff <= x_ff + 1'b1;
                  state_ff   <= S_CNT_DIV;
               end
            end
            S_SQ_DIV: begin
               if (div_st.done) begin
                  y_ff     <= ((N+1)'(x_ff) + (N+1)'(div_q)) >> 1;
                  state_ff <= S_SQ_CHK;
               end
            end
            S_CNT_DIV: begin
               if (div_st.done) begin
                  count_ff   <= CW'(r_ff) + CW'(div_q);
                  idx_ff     <= '0;
                  v_ff       <= n_ff;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= n_ff;
                  div_den_ff <= n_ff;
                  state_ff   <= S_F_H;
               end
            end
            S_F_V: begin
               if (div_st.done) begin
                  v_ff       <= div_q;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= n_ff;
                  div_den_ff <= div_q;
                  state_ff   <= S_F_H;
               end
            end
            S_F_H: begin
               if (div_st.done) begin
                  high_ff  <= div_q;
                  tri_ff   <= (2*N+1)'(v_ff) * ((2*N+1)'(v_ff) + 1'b1);
                  state_ff <= S_F_W;
               end
            end
            S_F_W: begin
               idx_ff <= idx_ff + 1'b1;
               if (high_ff == n_ff) begin
                  p_ff     <= RW'(2);
                  state_ff <= (r_ff < RW'(2)) ? S_FIN_RD : S_P_RD0;
               end else begin
                  div_go_ff  <= 1'b1;
                  div_num_ff <= n_ff;
                  div_den_ff <= high_ff + 1'b1;
                  state_ff   <= S_F_V;
               end
            end
            S_P_RD0: begin
               sq_ff    <= (2*RW)'(p_ff) * (2*RW)'(p_ff);
               state_ff <= S_P_RD1;
            end
            S_P_RD1: begin
               before_ff <= ps_val;
               state_ff  <= S_P_CMP;
            end
            S_P_CMP: begin
               i_ff     <= '0;
               state_ff <= (ps_val == before_ff) ? S_P_NX : S_I_CHK;
            end
            S_P_NX: begin
               p_ff     <= p_ff + 1'b1;
               state_ff <= (p_ff >= r_ff) ? S_FIN_RD : S_P_RD0;
            end
            S_I_CHK: begin
               state_ff <= (i_ff < count_ff && 32'(i_ff) < TABLE_DEPTH) ? S_I_VAL : S_P_NX;
            end
            S_I_VAL: begin
               if ((2*RW+N)'(qv_rd_ff) >= (2*RW+N)'(sq_ff)) begin
                  div_go_ff  <= 1'b1;
                  div_num_ff <= qv_rd_ff;
                  div_den_ff <= N'(p_ff);
                  state_ff   <= S_I_Q;
               end else begin
                  state_ff <= S_P_NX;
               end
            end
            S_I_Q: begin
               if (div_st.done) begin
                  if (div_q <= N'(r_ff)) begin
                     slot_ff  <= count_ff - CW'(div_q);
                     state_ff <= S_I_RS;
                  end else begin
                     div_go_ff  <= 1'b1;
                     div_num_ff <= n_ff;
                     div_den_ff <= div_q;
                     state_ff   <= S_I_POS;
                  end
               end
            end
            S_I_POS: begin
               if (div_st.done) begin
                  if (32'(div_q) < LARGE_DEPTH) begin
                     pos_ff   <= div_q;
                     state_ff <= S_I_LA;
                  end else begin
                     slot_ff  <= '0;
                     state_ff <= S_I_RS;
                  end
               end
            end
            S_I_LA: state_ff <= S_I_LS;
            S_I_LS: begin
               slot_ff  <= ls_rd_ff;
               state_ff <= S_I_RS;
            end
            S_I_RS: state_ff <= S_I_RR;
            S_I_RR: begin
               diff_ff  <= ps_val - before_ff;
               state_ff <= S_I_M0;
            end
            S_I_M0: begin
               cur_ff   <= ps_val;
               lo_ff    <= SW'(mul_lo);
               state_ff <= S_I_M1;
            end
            S_I_M1: begin
               hi_ff    <= SW'(mul_hi) << N;
               state_ff <= S_I_WR;
            end
            S_I_WR: begin
               i_ff     <= i_ff + 1'b1;
               state_ff <= S_I_CHK;
            end
            S_FIN_RD: state_ff <= S_FIN;
            S_FIN: begin
               res_ff   <= PRIME_SUM_BITS'(ps_val);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sum_ff   <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prime_sum = rsp_sum_ff;

   a_small_fast: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_endpoint < N'(2)) |=> state_ff == S_OUT)
      else $error("small endpoint did not go straight to output");
   a_p_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_RD0) |-> (p_ff >= RW'(2) && p_ff <= r_ff))
      else $error("sieve prime out of range");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !div_st.busy) else $error("divider started while busy");
   a_i_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_I_WR) |-> i_ff < count_ff) else $error("sieve index past count");

endmodule

// ===== dv/tb_prime_sum_sieve_unit.sv =====
// tb_prime_sum_sieve_unit: self-checking testbench for prime_sum_sieve_unit.
// Drives endpoints, predicts each prime sum with its own sieve, checks every rsp beat.
// Depends on pss_pkg and the prime_sum_sieve_unit RTL.
`timescale 1ns / 1ps

module tb_prime_sum_sieve_unit;
   import pss_pkg::*;

   localparam int EP_BITS   = 24;
   localparam int CYCLE_MAX = 40000000;

   typedef logic [PRIME_SUM_BITS-1:0] sum_t;
   typedef logic [EP_BITS-1:0] ep_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ep_t  req_endpoint = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sum_t rsp_prime_sum;

   sum_t expected_sums[$];
   int   errors = 0;
   int   cycles = 0;
   int   hold_cycles = 0;
   int   stall_left = 0;
   bit   no_idle = 1'b0;

   prime_sum_sieve_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_endpoint(req_endpoint),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_prime_sum(rsp_prime_sum)
   );

   always #5 clock = ~clock;

   function automatic sum_t prime_sum_upto(longint unsigned n);
      longint unsigned root, below, sq, d, t;
      longint unsigned small_sum[];
      longint unsigned big_sum[];
      if (n < 2) return '0;
      root = n;
      t = (root + 1) / 2;
      while (t < root) begin
         root = t;
         t = (root + n / root) / 2;
      end
      small_sum = new[root + 1];
      big_sum = new[root + 1];
      for (longint unsigned v = 0; v <= root; v++)
         small_sum[v] = (v < 2) ? 0 : v * (v + 1) / 2 - 1;
      for (longint unsigned k = 1; k <= root; k++) begin
         d = n / k;
         big_sum[k] = d * (d + 1) / 2 - 1;
      end
      for (longint unsigned p = 2; p <= root; p++) begin
         if (small_sum[p] == small_sum[p-1]) continue;
         below = small_sum[p-1];
         sq = p * p;
         for (longint unsigned k = 1; k <= root && n / k >= sq; k++) begin
            d = k * p;
            t = (d <= root) ? big_sum[d] : small_sum[n / d];
            big_sum[k] -= p * (t - below);
         end
         for (longint unsigned v = root; v >= sq; v--)
            small_sum[v] -= p * (small_sum[v / p] - below);
      end
      return big_sum[1][PRIME_SUM_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input sum_t got, input sum_t want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic send_endpoint(input ep_t n);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_endpoint <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_sums.push_back(prime_sum_upto(n));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // result side: check beat, then draw its own stall
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("unexpected beat", rsp_prime_sum, '0);
         end else begin
            if (rsp_prime_sum !== expected_sums[0])
               report_mismatch("prime_sum", rsp_prime_sum, expected_sums[0]);
            void'(expected_sums.pop_front());
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_MAX) begin
         $display("FAIL prime_sum_sieve_unit");
         $finish;
      end
   end

   task automatic test_directed();
      ep_t corner[$] = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd8, 24'd9,
                         24'd24, 24'd25, 24'd26, 24'd255, 24'd1023, 24'd1024,
                         24'd1025, 24'd65535, 24'hFFFFFF, 24'd1, 24'd0};
      foreach (corner[i]) send_endpoint(corner[i]);
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         hold_cycles = 6000;
         repeat (4) send_endpoint(ep_t'($urandom_range(0, 300)));
      join
      wait_drained();
   endtask

   task automatic test_no_idle();
      no_idle = 1'b1;
      repeat (10) send_endpoint(ep_t'($urandom_range(0, 200)));
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      ep_t n;
      repeat (85) begin
         case ($urandom_range(0, 9))
            0: n = ep_t'($urandom_range(0, 1));
            1: n = ep_t'($urandom_range(1000, 5000));
            default: n = ep_t'($urandom_range(2, 600));
         endcase
         send_endpoint(n);
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_no_idle();
      test_random();
      if (errors == 0 && expected_sums.size() == 0) begin
         $display("PASS prime_sum_sieve_unit");
      end else begin
         $display("FAIL prime_sum_sieve_unit");
      end
      $finish;
   end

endmodule
